[hdl/spvf_pkg.sv]
// Shared widths, codes and the controller/datapath interface of the spanning-vertex flagger.
package spvf_pkg;

  // Field widths.
  localparam int COORD_W  = 24;                 // signed Q12.12 coordinate
  localparam int TOL_W    = 24;                 // tolerance, unsigned Q12.12
  localparam int INDEX_W  = 16;                 // result point index

  // Datapath widths.
  localparam int DIFF_W   = COORD_W + 1;        // coordinate difference
  localparam int MUL_W    = DIFF_W + 1;         // signed multiplier operand
  localparam int PROD_W   = 2 * MUL_W;          // signed product
  localparam int PIECE_W  = DIFF_W;             // low piece of a 50-bit magnitude
  localparam int LEN_W    = 2 * DIFF_W;         // squared chord length / |cross|
  localparam int DOT_W    = LEN_W + 2;          // signed dot product
  localparam int TOL2_W   = 2 * TOL_W;          // squared tolerance
  localparam int ACC_W    = 2 * LEN_W + 2;      // wide signed accumulator

  // Point counter: saturates at MAX_POINTS.
  localparam int MAX_POINTS = 65536;
  localparam int SEEN_W     = $clog2(MAX_POINTS + 1);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4);

  // Multiplier operand pairs.
  typedef enum logic [4:0] {
    MUL_TOLTOL,
    MUL_DXDX,
    MUL_DYDY,
    MUL_DXWX,
    MUL_DYWY,
    MUL_WXWX,
    MUL_WYWY,
    MUL_UXUX,
    MUL_UYUY,
    MUL_DXWY,
    MUL_DYWX,
    MUL_CHCH,
    MUL_CHCL,
    MUL_CLCL,
    MUL_THLH,
    MUL_THLL,
    MUL_TLLH,
    MUL_TLLL
  } mul_sel_t;

  // What happens to the registered product in the cycle after issue.
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_TOL2
  } acc_op_t;

  // Left shift of the product before accumulation.
  typedef enum logic [2:0] {
    SH_NONE,     // 0
    SH_LO_T,     // tolerance piece weight
    SH_LO_P,     // magnitude piece weight
    SH_CROSS,    // doubled hi*lo term
    SH_HI_TP,    // tol hi * len hi
    SH_HI_PP     // hi * hi
  } shift_t;

  typedef enum logic {
    JSEL_STEP,   // predecessor, vertex, new point
    JSEL_CLOSE   // tour closure around point 0
  } jsel_t;

  typedef enum logic [1:0] {
    IDX_PREV,
    IDX_ZERO,
    IDX_LAST
  } idx_sel_t;

  typedef enum logic [1:0] {
    SPAN_FAR,
    SPAN_ONE,
    SPAN_TOUR    // judged flag on a closed tour, else 1
  } span_sel_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_DECIDE,
    S_FIN,
    S_JLOAD,
    S_LEN_A,
    S_LEN_B,
    S_DOT_A,
    S_DOT_B,
    S_DOT_W,
    S_BRANCH,
    S_PW_A,
    S_PW_B,
    S_PU_A,
    S_PU_B,
    S_PT,
    S_CR_A,
    S_CR_B,
    S_CR_T,
    S_CR_S,
    S_Q_HH,
    S_Q_HL,
    S_Q_LL,
    S_R_HH,
    S_R_HL,
    S_R_LH,
    S_R_LL,
    S_WAIT,
    S_DONE,
    S_EMIT_STEP,
    S_EMIT_HEAD,
    S_EMIT_TAIL,
    S_EMIT_LONE,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic      capture;
    logic      jload;
    jsel_t     jsel;
    mul_sel_t  mul_sel;
    acc_op_t   acc_op;
    shift_t    shift;
    logic      save_len;
    logic      save_cross;
    logic      latch_far;
    logic      emit;
    idx_sel_t  idx_sel;
    span_sel_t span_sel;
    logic      run_end;
    logic      commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_ge2;
    logic idx_zero;
    logic fin;
    logic closed;
    logic dot_le0;
    logic dot_ge_len;
    logic out_free;
  } dp_status_t;

endpackage

[hdl/spvf_ctrl.sv]
// Sequencer for the spanning-vertex flagger: point handling and the multiply schedule.
module spvf_ctrl
  import spvf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       point_valid,
  output logic       point_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;
  logic   jclose, jclose_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      jclose <= 1'b0;
    end else begin
      state  <= state_next;
      jclose <= jclose_next;
    end
  end

  // Next state.
  always_comb begin
    state_next  = state;
    jclose_next = jclose;
    unique case (state)
      S_IDLE:      if (point_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        if (status.idx_ge2) begin
          state_next  = S_JLOAD;
          jclose_next = 1'b0;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        priority if (!status.fin) state_next = S_COMMIT;
        else if (status.idx_zero) state_next = S_EMIT_LONE;
        else if (status.closed) begin
          state_next  = S_JLOAD;
          jclose_next = 1'b1;
        end else state_next = S_EMIT_HEAD;
      end
      S_JLOAD:     state_next = S_LEN_A;
      S_LEN_A:     state_next = S_LEN_B;
      S_LEN_B:     state_next = S_DOT_A;
      S_DOT_A:     state_next = S_DOT_B;
      S_DOT_B:     state_next = S_DOT_W;
      S_DOT_W:     state_next = S_BRANCH;
      S_BRANCH: begin
        priority if (status.dot_le0) state_next = S_PW_A;
        else if (status.dot_ge_len)  state_next = S_PU_A;
        else                         state_next = S_CR_A;
      end
      S_PW_A:      state_next = S_PW_B;
      S_PW_B:      state_next = S_PT;
      S_PU_A:      state_next = S_PU_B;
      S_PU_B:      state_next = S_PT;
      S_PT:        state_next = S_WAIT;
      S_CR_A:      state_next = S_CR_B;
      S_CR_B:      state_next = S_CR_T;
      S_CR_T:      state_next = S_CR_S;
      S_CR_S:      state_next = S_Q_HH;
      S_Q_HH:      state_next = S_Q_HL;
      S_Q_HL:      state_next = S_Q_LL;
      S_Q_LL:      state_next = S_R_HH;
      S_R_HH:      state_next = S_R_HL;
      S_R_HL:      state_next = S_R_LH;
      S_R_LH:      state_next = S_R_LL;
      S_R_LL:      state_next = S_WAIT;
      S_WAIT:      state_next = S_DONE;
      S_DONE:      state_next = jclose ? S_EMIT_HEAD : S_EMIT_STEP;
      S_EMIT_STEP: if (status.out_free) state_next = S_FIN;
      S_EMIT_HEAD: if (status.out_free) state_next = S_EMIT_TAIL;
      S_EMIT_TAIL: if (status.out_free) state_next = S_COMMIT;
      S_EMIT_LONE: if (status.out_free) state_next = S_COMMIT;
      S_COMMIT:    state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd         = '0;
    point_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE:  cmd.capture = point_valid;
      S_JLOAD: begin
        cmd.jload = 1'b1;
        cmd.jsel  = jclose ? JSEL_CLOSE : JSEL_STEP;
      end
      S_LEN_A: begin cmd.mul_sel = MUL_DXDX; cmd.acc_op = ACC_LOAD; end
      S_LEN_B: begin cmd.mul_sel = MUL_DYDY; cmd.acc_op = ACC_ADD;  end
      S_DOT_A: begin cmd.mul_sel = MUL_DXWX; cmd.acc_op = ACC_LOAD; end
      S_DOT_B: begin
        cmd.mul_sel  = MUL_DYWY;
        cmd.acc_op   = ACC_ADD;
        cmd.save_len = 1'b1;
      end
      S_PW_A:  begin cmd.mul_sel = MUL_WXWX;   cmd.acc_op = ACC_LOAD; end
      S_PW_B:  begin cmd.mul_sel = MUL_WYWY;   cmd.acc_op = ACC_ADD;  end
      S_PU_A:  begin cmd.mul_sel = MUL_UXUX;   cmd.acc_op = ACC_LOAD; end
      S_PU_B:  begin cmd.mul_sel = MUL_UYUY;   cmd.acc_op = ACC_ADD;  end
      S_PT:    begin cmd.mul_sel = MUL_TOLTOL; cmd.acc_op = ACC_SUB;  end
      S_CR_A:  begin cmd.mul_sel = MUL_DXWY;   cmd.acc_op = ACC_LOAD; end
      S_CR_B:  begin cmd.mul_sel = MUL_DYWX;   cmd.acc_op = ACC_SUB;  end
      S_CR_T:  begin cmd.mul_sel = MUL_TOLTOL; cmd.acc_op = ACC_TOL2; end
      S_CR_S:  cmd.save_cross = 1'b1;
      S_Q_HH: begin
        cmd.mul_sel = MUL_CHCH; cmd.acc_op = ACC_LOAD; cmd.shift = SH_HI_PP;
      end
      S_Q_HL: begin
        cmd.mul_sel = MUL_CHCL; cmd.acc_op = ACC_ADD; cmd.shift = SH_CROSS;
      end
      S_Q_LL: begin cmd.mul_sel = MUL_CLCL; cmd.acc_op = ACC_ADD; end
      S_R_HH: begin
        cmd.mul_sel = MUL_THLH; cmd.acc_op = ACC_SUB; cmd.shift = SH_HI_TP;
      end
      S_R_HL: begin
        cmd.mul_sel = MUL_THLL; cmd.acc_op = ACC_SUB; cmd.shift = SH_LO_T;
      end
      S_R_LH: begin
        cmd.mul_sel = MUL_TLLH; cmd.acc_op = ACC_SUB; cmd.shift = SH_LO_P;
      end
      S_R_LL:  begin cmd.mul_sel = MUL_TLLL; cmd.acc_op = ACC_SUB; end
      S_DONE:  cmd.latch_far = 1'b1;
      S_EMIT_STEP: begin
        cmd.emit     = status.out_free;
        cmd.idx_sel  = IDX_PREV;
        cmd.span_sel = SPAN_FAR;
      end
      S_EMIT_HEAD: begin
        cmd.emit     = status.out_free;
        cmd.idx_sel  = IDX_ZERO;
        cmd.span_sel = SPAN_TOUR;
      end
      S_EMIT_TAIL: begin
        cmd.emit     = status.out_free;
        cmd.idx_sel  = IDX_LAST;
        cmd.span_sel = SPAN_TOUR;
        cmd.run_end  = 1'b1;
      end
      S_EMIT_LONE: begin
        cmd.emit     = status.out_free;
        cmd.idx_sel  = IDX_ZERO;
        cmd.span_sel = SPAN_ONE;
        cmd.run_end  = 1'b1;
      end
      S_COMMIT: cmd.commit = 1'b1;
      default: ;
    endcase
  end

endmodule

[hdl/spvf_dp.sv]
// Datapath: point history, coordinate differences, shared multiplier, accumulator, result register.
module spvf_dp
  import spvf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  output dp_status_t                status,
  input  logic        [TOL_W-1:0]   tolerance,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic                      final_point,
  output logic                      flag_valid,
  input  logic                      flag_stall,
  output logic        [INDEX_W-1:0] point_index,
  output logic                      spanning,
  output logic                      run_end
);

  // Point history.
  logic signed [COORD_W-1:0] cur_x, cur_y, first_x, first_y, second_x, second_y;
  logic signed [COORD_W-1:0] older_x, older_y, newer_x, newer_y;
  logic                      fin;
  logic        [SEEN_W-1:0]  seen;

  // Judged triangle: chord a-b, vertex p.
  logic signed [COORD_W-1:0] a_x, a_y, p_x, p_y, b_x, b_y;
  logic signed [DIFF_W-1:0]  dx, dy, wx, wy, ux, uy;

  // Arithmetic.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  acc_op_t                  op_q;
  shift_t                   sh_q;
  logic signed [ACC_W-1:0]  prod_ext, term, acc;
  logic        [ACC_W-1:0]  acc_abs;
  logic        [LEN_W-1:0]  len2, cabs;
  logic        [TOL2_W-1:0] tol2;
  logic                     far;
  logic        [INDEX_W-1:0] index_sel;
  logic                     span_sel;

  // Capture and commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (cmd.commit) begin
      if (fin) seen <= '0;
      else if (seen < SEEN_W'(MAX_POINTS)) seen <= seen + SEEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_x <= coord_x;
      cur_y <= coord_y;
      fin   <= final_point;
      if (seen == '0) begin
        first_x <= coord_x;
        first_y <= coord_y;
      end
      if (seen == SEEN_W'(1)) begin
        second_x <= coord_x;
        second_y <= coord_y;
      end
    end
    if (cmd.commit) begin
      older_x <= newer_x;
      older_y <= newer_y;
      newer_x <= cur_x;
      newer_y <= cur_y;
    end
  end

  // Triangle selection.
  always_comb begin
    unique case (cmd.jsel)
      JSEL_STEP: begin
        a_x = older_x; a_y = older_y;
        p_x = newer_x; p_y = newer_y;
        b_x = cur_x;   b_y = cur_y;
      end
      JSEL_CLOSE: begin
        a_x = status.idx_ge2 ? newer_x : first_x;
        a_y = status.idx_ge2 ? newer_y : first_y;
        p_x = first_x;  p_y = first_y;
        b_x = second_x; b_y = second_y;
      end
      default: begin
        a_x = older_x; a_y = older_y;
        p_x = newer_x; p_y = newer_y;
        b_x = cur_x;   b_y = cur_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.jload) begin
      dx <= {b_x[COORD_W-1], b_x} - {a_x[COORD_W-1], a_x};
      dy <= {b_y[COORD_W-1], b_y} - {a_y[COORD_W-1], a_y};
      wx <= {p_x[COORD_W-1], p_x} - {a_x[COORD_W-1], a_x};
      wy <= {p_y[COORD_W-1], p_y} - {a_y[COORD_W-1], a_y};
      ux <= {p_x[COORD_W-1], p_x} - {b_x[COORD_W-1], b_x};
      uy <= {p_y[COORD_W-1], p_y} - {b_y[COORD_W-1], b_y};
    end
  end

  // Operand select: differences sign-extend, magnitude pieces zero-extend.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_TOLTOL: begin mul_a = {2'b00, tolerance}; mul_b = {2'b00, tolerance}; end
      MUL_DXDX:   begin mul_a = {dx[DIFF_W-1], dx}; mul_b = {dx[DIFF_W-1], dx}; end
      MUL_DYDY:   begin mul_a = {dy[DIFF_W-1], dy}; mul_b = {dy[DIFF_W-1], dy}; end
      MUL_DXWX:   begin mul_a = {dx[DIFF_W-1], dx}; mul_b = {wx[DIFF_W-1], wx}; end
      MUL_DYWY:   begin mul_a = {dy[DIFF_W-1], dy}; mul_b = {wy[DIFF_W-1], wy}; end
      MUL_WXWX:   begin mul_a = {wx[DIFF_W-1], wx}; mul_b = {wx[DIFF_W-1], wx}; end
      MUL_WYWY:   begin mul_a = {wy[DIFF_W-1], wy}; mul_b = {wy[DIFF_W-1], wy}; end
      MUL_UXUX:   begin mul_a = {ux[DIFF_W-1], ux}; mul_b = {ux[DIFF_W-1], ux}; end
      MUL_UYUY:   begin mul_a = {uy[DIFF_W-1], uy}; mul_b = {uy[DIFF_W-1], uy}; end
      MUL_DXWY:   begin mul_a = {dx[DIFF_W-1], dx}; mul_b = {wy[DIFF_W-1], wy}; end
      MUL_DYWX:   begin mul_a = {dy[DIFF_W-1], dy}; mul_b = {wx[DIFF_W-1], wx}; end
      MUL_CHCH: begin
        mul_a = {1'b0, cabs[LEN_W-1:PIECE_W]};
        mul_b = {1'b0, cabs[LEN_W-1:PIECE_W]};
      end
      MUL_CHCL: begin
        mul_a = {1'b0, cabs[LEN_W-1:PIECE_W]};
        mul_b = {1'b0, cabs[PIECE_W-1:0]};
      end
      MUL_CLCL: begin
        mul_a = {1'b0, cabs[PIECE_W-1:0]};
        mul_b = {1'b0, cabs[PIECE_W-1:0]};
      end
      MUL_THLH: begin
        mul_a = {2'b00, tol2[TOL2_W-1:TOL_W]};
        mul_b = {1'b0, len2[LEN_W-1:PIECE_W]};
      end
      MUL_THLL: begin
        mul_a = {2'b00, tol2[TOL2_W-1:TOL_W]};
        mul_b = {1'b0, len2[PIECE_W-1:0]};
      end
      MUL_TLLH: begin
        mul_a = {2'b00, tol2[TOL_W-1:0]};
        mul_b = {1'b0, len2[LEN_W-1:PIECE_W]};
      end
      MUL_TLLL: begin
        mul_a = {2'b00, tol2[TOL_W-1:0]};
        mul_b = {1'b0, len2[PIECE_W-1:0]};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Product register, then accumulate in the cycle after.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    sh_q <= cmd.shift;
  end

  always_ff @(posedge clk) begin
    if (rst) op_q <= ACC_NONE;
    else     op_q <= cmd.acc_op;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    unique case (sh_q)
      SH_NONE:  term = prod_ext;
      SH_LO_T:  term = prod_ext <<< TOL_W;
      SH_LO_P:  term = prod_ext <<< PIECE_W;
      SH_CROSS: term = prod_ext <<< (PIECE_W + 1);
      SH_HI_TP: term = prod_ext <<< (TOL_W + PIECE_W);
      SH_HI_PP: term = prod_ext <<< (2 * PIECE_W);
      default:  term = prod_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (op_q)
      ACC_LOAD: acc  <= term;
      ACC_ADD:  acc  <= acc + term;
      ACC_SUB:  acc  <= acc - term;
      ACC_TOL2: tol2 <= prod[TOL2_W-1:0];
      default: ;
    endcase
  end

  assign acc_abs = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;

  always_ff @(posedge clk) begin
    if (cmd.save_len)   len2 <= acc[LEN_W-1:0];
    if (cmd.save_cross) cabs <= acc_abs[LEN_W-1:0];
    if (cmd.latch_far)  far  <= ~acc[ACC_W-1];
  end

  // Status.
  assign status.idx_ge2    = (seen >= SEEN_W'(2));
  assign status.idx_zero   = (seen == '0);
  assign status.fin        = fin;
  assign status.closed     = (cur_x == first_x) && (cur_y == first_y);
  assign status.dot_le0    = acc[ACC_W-1] || (acc == '0);
  assign status.dot_ge_len = $signed(acc[DOT_W-1:0]) >= $signed({2'b00, len2});
  assign status.out_free   = !flag_valid || !flag_stall;

  // Result register.
  always_comb begin
    unique case (cmd.idx_sel)
      IDX_PREV: index_sel = INDEX_W'(seen - SEEN_W'(1));
      IDX_ZERO: index_sel = '0;
      IDX_LAST: index_sel = (seen > SEEN_W'({INDEX_W{1'b1}})) ? {INDEX_W{1'b1}}
                                                               : seen[INDEX_W-1:0];
      default:  index_sel = '0;
    endcase
    unique case (cmd.span_sel)
      SPAN_FAR:  span_sel = far;
      SPAN_ONE:  span_sel = 1'b1;
      SPAN_TOUR: span_sel = status.closed ? far : 1'b1;
      default:   span_sel = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_valid <= 1'b0;
    end else if (cmd.emit) begin
      flag_valid <= 1'b1;
    end else if (!flag_stall) begin
      flag_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      point_index <= index_sel;
      spanning    <= span_sel;
      run_end     <= cmd.run_end;
    end
  end

endmodule

[hdl/polyline_spanning_vertex_flags.sv]
// Top level of the polyline spanning-vertex flagger: tolerance register, controller, datapath.
// Points are taken one at a time: the point channel stalls until the previous point is done. A
//   point whose vertex foot falls outside its chord takes a shorter path than the full
//   cross-product test; the closing point of a closed tour adds a second test. All products
//   come from the single 26x26 multiplier, issuing one product per cycle.
// Reset (synchronous, active high): tolerance returns to 4, point count to zero, output empty.
module polyline_spanning_vertex_flags
  import spvf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // Tolerance register write port.
  input  logic                      cfg_write,
  input  logic        [TOL_W-1:0]   cfg_data,
  // Point channel.
  input  logic                      point_valid,
  output logic                      point_stall,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic                      final_point,
  // Flag channel.
  output logic                      flag_valid,
  input  logic                      flag_stall,
  output logic        [INDEX_W-1:0] point_index,
  output logic                      spanning,
  output logic                      run_end
);

  // Tolerance; the user must write it only while no transaction is in flight, the block does not enforce this.
  logic [TOL_W-1:0] tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_write) begin
      tolerance <= cfg_data;
    end
  end

  // Controller drives one command word per cycle; the datapath returns
  // the branch conditions (point count class, closed tour, foot position)
  // and whether the result register can take a new flag.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Per point: capture, then (from the third point on) judge the previous
  // vertex against the chord from its predecessor to the new point. The
  // judgment squares the chord, takes the dot product to place the foot,
  // then either a point-to-end distance or cross^2 - tol^2 * len^2 from
  // 25- and 24-bit pieces. The final point adds two end flags (one if lone).
  spvf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .status      (status),
    .cmd         (cmd)
  );

  spvf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .tolerance   (tolerance),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .final_point (final_point),
    .flag_valid  (flag_valid),
    .flag_stall  (flag_stall),
    .point_index (point_index),
    .spanning    (spanning),
    .run_end     (run_end)
  );

endmodule

[hdl/spvf_props.sv]
// Port-level checks for the spanning-vertex flagger, bound to the top level.
module spvf_props
  import spvf_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      point_valid,
  input logic                      point_stall,
  input logic                      flag_valid,
  input logic                      flag_stall,
  input logic        [INDEX_W-1:0] point_index,
  input logic                      spanning,
  input logic                      run_end
);

  // Out of reset: no flag pending, points taken.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !flag_valid && !point_stall)
    else $error("flag pending or point stalled after reset");

  // Stalled flag holds.
  a_flag_hold: assert property (@(posedge clk) disable iff (rst)
    flag_valid && flag_stall |=>
      flag_valid && $stable(point_index) && $stable(spanning) && $stable(run_end))
    else $error("stalled flag changed");

  // One point at a time: a taken point blocks the next cycle.
  a_point_spacing: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_stall |=> point_stall)
    else $error("points taken back to back");

endmodule

bind polyline_spanning_vertex_flags spvf_props u_spvf_props (.*);
